// ===== rtl/dcr_pkg.sv =====
`timescale 1ns / 1ps

package dcr_pkg;

    // configuration file
    localparam int NUM_REGS = 8;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_ADDR_LIMIT = CFG_ADDR_W'(NUM_REGS);

    // one signed 32-bit half of a configuration register
    typedef logic signed [31:0] word_t;

    // depths at or above this are no return
    localparam logic [15:0] MAX_DEPTH = 16'd700;

    // Q.28 accumulator to Q24.8: half of one output lsb
    localparam int ACC_W = 58;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd524288);
    localparam logic signed [37:0] POS_MAX = 38'sd2147483647;
    localparam logic signed [37:0] POS_MIN = -38'sd2147483648;

    // quotient bits kept by the divider; larger quotients saturate
    localparam int QBITS = 35;

    // projection: half a pixel in Q.12 and the negative index bound
    localparam int U_W = 38;
    localparam logic signed [U_W-1:0] PIX_HALF = 38'sd2048;
    localparam logic signed [U_W-1:0] PIX_NEG_BOUND = -38'sd4096;

    typedef struct packed {
        logic        valid;
        logic        depth_valid;
        word_t       pos_x;
        word_t       pos_y;
        word_t       pos_z;
        logic [10:0] color_col;
        logic [10:0] color_row;
        logic        in_bounds;
    } result_t;

endpackage

// ===== rtl/depth_to_color_registration.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          beat contents
// cfg       in   cfg_wr_en          cfg_addr, cfg_wr_data (64-bit register)
// s_        in   s_valid/s_ready    pixel column, row, raw depth
// m_        out  m_valid/m_ready    position in color frame, color pixel, flags
//
// one beat per cycle sustained while the skid register is empty
// the pipeline depth is set by the divide by z: one quotient bit per stage, 35 stages
// aresetn is synchronous, active low; clears config and every valid bit
// a stall parks the last result in a skid register; s_ready drops only once
// that skid register is full and the whole pipeline then holds in place

module depth_to_color_registration #(
    parameter int COLOR_WIDTH  = 1920,
    parameter int COLOR_HEIGHT = 1080,
    parameter int DEPTH_WIDTH  = 1024,
    parameter int DEPTH_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  dcr_pkg::cfg_addr_t             cfg_addr,
    input  logic [dcr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [9:0]                     s_pixel_col,
    input  logic [9:0]                     s_pixel_row,
    input  logic [15:0]                    s_depth_raw,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_depth_valid,
    output logic signed [31:0]             m_pos_x,
    output logic signed [31:0]             m_pos_y,
    output logic signed [31:0]             m_pos_z,
    output logic [10:0]                    m_color_col,
    output logic [10:0]                    m_color_row,
    output logic                           m_in_bounds
);
    import dcr_pkg::*;

    logic [CFG_DATA_W-1:0] cfg_reg [NUM_REGS];

    // register halves in order: A00..A22, tx, ty, tz, fx, fy, cx, cy
    word_t half_w [16];
    word_t coef_a [3][3];
    word_t trans  [3];
    word_t focal  [2];
    word_t center [2];

    logic    pipe_en;
    logic    bp_valid;
    logic    bp_dval;
    word_t   bp_pos [3];
    result_t pipe_res;
    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    logic    take;

    // config writes; addresses past the register file are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                cfg_reg[k] <= '0;
            end
        end else if (cfg_wr_en && (cfg_addr < CFG_ADDR_LIMIT)) begin
            cfg_reg[cfg_addr[2:0]] <= cfg_wr_data;
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            half_w[k] = cfg_reg[3'(k >> 1)][32 * (k & 1) +: 32];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef_a[i][j] = half_w[3 * i + j];
            end
            trans[i] = half_w[9 + i];
        end
        focal[0]  = half_w[12];
        focal[1]  = half_w[13];
        center[0] = half_w[14];
        center[1] = half_w[15];
    end

    // whole pipeline moves together while the skid register is free
    assign pipe_en = !skid_reg.valid;
    assign s_ready = pipe_en;

    // back-projection: column/row products, sum, depth scale, round, saturate
    dcr_backproj #(
        .DEPTH_WIDTH  (DEPTH_WIDTH),
        .DEPTH_HEIGHT (DEPTH_HEIGHT)
    ) u_backproj (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (pipe_en),
        .in_valid        (s_valid && s_ready),
        .pixel_col       (s_pixel_col),
        .pixel_row       (s_pixel_row),
        .depth_raw       (s_depth_raw),
        .coef_a          (coef_a),
        .trans           (trans),
        .out_valid       (bp_valid),
        .out_depth_valid (bp_dval),
        .pos             (bp_pos)
    );

    // projection: f * p, divide by z, round to a pixel, bounds check
    dcr_project #(
        .COLOR_WIDTH  (COLOR_WIDTH),
        .COLOR_HEIGHT (COLOR_HEIGHT)
    ) u_project (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (pipe_en),
        .in_valid       (bp_valid),
        .in_depth_valid (bp_dval),
        .pos            (bp_pos),
        .focal          (focal),
        .center         (center),
        .res            (pipe_res)
    );

    // a pipeline result leaves its stage on every enabled edge
    assign take = pipe_en && pipe_res.valid;

    always_comb begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (!out_reg.valid || m_ready) begin
            // output slot frees up: skid first, else straight from the pipe
            if (skid_reg.valid) begin
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end else if (take) begin
                out_next = pipe_res;
            end else begin
                out_next.valid = 1'b0;
            end
        end else if (take) begin
            // output stalled, park the beat
            skid_next = pipe_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg  <= '0;
            skid_reg <= '0;
        end else begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign m_valid       = out_reg.valid;
    assign m_depth_valid = out_reg.depth_valid;
    assign m_pos_x       = out_reg.pos_x;
    assign m_pos_y       = out_reg.pos_y;
    assign m_pos_z       = out_reg.pos_z;
    assign m_color_col   = out_reg.color_col;
    assign m_color_row   = out_reg.color_row;
    assign m_in_bounds   = out_reg.in_bounds;

`ifndef SYNTHESIS
    // the skid register only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid register holds a beat while output is empty");

    // a full skid register must hold the input side off
    a_skid_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> !s_ready)
        else $error("input accepted while skid register is full");

    // a rejected depth carries a zero position
    a_invalid_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_depth_valid) |->
        (m_pos_x == 32'sd0 && m_pos_y == 32'sd0 && m_pos_z == 32'sd0 && !m_in_bounds))
        else $error("invalid depth with nonzero result");

    // an in-bounds pixel needs a valid depth and a positive z
    a_in_bounds_needs_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_bounds) |-> (m_depth_valid && m_pos_z > 32'sd0))
        else $error("in-bounds pixel without valid depth or positive z");
`endif

endmodule

// ===== rtl/dcr_divider.sv =====
`timescale 1ns / 1ps

module dcr_divider (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [63:0]               dividend,
    input  logic [31:0]               divisor,
    output logic [dcr_pkg::QBITS-1:0] quotient
);
    import dcr_pkg::*;

    logic [31:0]      rem_reg [QBITS];
    logic [QBITS-1:0] low_reg [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];
    logic [31:0]      dsr_reg [QBITS];
    logic             ovf_reg [QBITS];

    logic [31:0]      rem_in   [QBITS];
    logic [QBITS-1:0] low_in   [QBITS];
    logic [QBITS-1:0] quo_in   [QBITS];
    logic [31:0]      dsr_in   [QBITS];
    logic             ovf_in   [QBITS];
    logic [32:0]      trial    [QBITS];
    logic             ge       [QBITS];
    logic [31:0]      rem_next [QBITS];

    // one restoring step per stage, msb of the quotient first
    always_comb begin
        for (int j = 0; j < QBITS; j++) begin
            if (j == 0) begin
                rem_in[j] = 32'(dividend[63:QBITS]);
                low_in[j] = dividend[QBITS-1:0];
                quo_in[j] = '0;
                dsr_in[j] = divisor;
                ovf_in[j] = 32'(dividend[63:QBITS]) >= divisor;
            end else begin
                rem_in[j] = rem_reg[j-1];
                low_in[j] = low_reg[j-1];
                quo_in[j] = quo_reg[j-1];
                dsr_in[j] = dsr_reg[j-1];
                ovf_in[j] = ovf_reg[j-1];
            end
            trial[j] = {rem_in[j], low_in[j][QBITS-1]};
            ge[j] = trial[j] >= {1'b0, dsr_in[j]};
            rem_next[j] = ge[j] ? 32'(trial[j] - {1'b0, dsr_in[j]}) : trial[j][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < QBITS; j++) begin
                rem_reg[j] <= rem_next[j];
                low_reg[j] <= low_in[j] << 1;
                quo_reg[j] <= {quo_in[j][QBITS-2:0], ge[j]};
                dsr_reg[j] <= dsr_in[j];
                ovf_reg[j] <= ovf_in[j];
            end
        end
    end

    assign quotient = ovf_reg[QBITS-1] ? '1 : quo_reg[QBITS-1];

endmodule

// ===== rtl/dcr_backproj.sv =====
`timescale 1ns / 1ps

module dcr_backproj #(
    parameter int DEPTH_WIDTH  = 1024,
    parameter int DEPTH_HEIGHT = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [9:0]     pixel_col,
    input  logic [9:0]     pixel_row,
    input  logic [15:0]    depth_raw,
    input  dcr_pkg::word_t coef_a [3][3],
    input  dcr_pkg::word_t trans [3],
    output logic           out_valid,
    output logic           out_depth_valid,
    output dcr_pkg::word_t pos [3]
);
    import dcr_pkg::*;

    logic [3:0]         valid_reg;
    logic [3:0]         dval_reg;
    logic [9:0]         depth1_reg;
    logic [9:0]         depth2_reg;
    logic signed [42:0] pc_reg   [3];
    logic signed [42:0] pr_reg   [3];
    logic signed [44:0] lin_reg  [3];
    logic signed [55:0] prod_reg [3];
    word_t              pos_reg  [3];

    logic                      in_ok;
    logic signed [42:0]        pc_next   [3];
    logic signed [42:0]        pr_next   [3];
    logic signed [44:0]        lin_next  [3];
    logic signed [55:0]        prod_next [3];
    logic signed [ACC_W-1:0]   acc       [3];
    logic signed [37:0]        scaled    [3];
    word_t                     pos_next  [3];

    assign in_ok = (depth_raw != 16'd0) && (depth_raw < MAX_DEPTH)
                && (13'(pixel_col) < 13'(DEPTH_WIDTH))
                && (13'(pixel_row) < 13'(DEPTH_HEIGHT));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pc_next[i] = coef_a[i][0] * $signed({1'b0, pixel_col});
            pr_next[i] = coef_a[i][1] * $signed({1'b0, pixel_row});
            lin_next[i] = 45'(pc_reg[i]) + 45'(pr_reg[i]) + 45'(coef_a[i][2]);
            prod_next[i] = $signed({1'b0, depth2_reg}) * lin_reg[i];
            acc[i] = ACC_W'(prod_reg[i]) + (ACC_W'(trans[i]) <<< 16) + ROUND_HALF;
            scaled[i] = acc[i][ACC_W-1:20];
            if (!dval_reg[2]) begin
                pos_next[i] = '0;
            end else if (scaled[i] > POS_MAX) begin
                pos_next[i] = POS_MAX[31:0];
            end else if (scaled[i] < POS_MIN) begin
                pos_next[i] = POS_MIN[31:0];
            end else begin
                pos_next[i] = scaled[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dval_reg   <= {dval_reg[2:0], in_ok};
            depth1_reg <= depth_raw[9:0];
            depth2_reg <= depth1_reg;
            for (int i = 0; i < 3; i++) begin
                pc_reg[i]   <= pc_next[i];
                pr_reg[i]   <= pr_next[i];
                lin_reg[i]  <= lin_next[i];
                prod_reg[i] <= prod_next[i];
                pos_reg[i]  <= pos_next[i];
            end
        end
    end

    assign out_valid       = valid_reg[3];
    assign out_depth_valid = dval_reg[3];
    assign pos             = pos_reg;

endmodule

// ===== rtl/dcr_project.sv =====
`timescale 1ns / 1ps

module dcr_project #(
    parameter int COLOR_WIDTH  = 1920,
    parameter int COLOR_HEIGHT = 1080
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic             in_depth_valid,
    input  dcr_pkg::word_t   pos [3],
    input  dcr_pkg::word_t   focal [2],
    input  dcr_pkg::word_t   center [2],
    output dcr_pkg::result_t res
);
    import dcr_pkg::*;

    typedef struct packed {
        logic       valid;
        logic       dval;
        logic       zpos;
        logic [1:0] neg;
        word_t      pos_x;
        word_t      pos_y;
        word_t      pos_z;
    } side_t;

    side_t              meta1_reg;
    side_t              meta2_reg;
    side_t              side_reg [QBITS];
    logic signed [63:0] prod_reg [2];
    logic [63:0]        mag_reg  [2];
    result_t            res_reg;

    side_t                 meta1_next;
    side_t                 meta2_next;
    logic signed [63:0]    prod_next [2];
    logic [QBITS-1:0]      quo       [2];
    logic signed [QBITS:0] q         [2];
    logic signed [U_W-1:0] u         [2];
    logic [25:0]           lim       [2];
    logic                  ok        [2];
    logic [10:0]           idx       [2];
    logic                  inb;
    result_t               res_next;

    always_comb begin
        meta1_next       = '0;
        meta1_next.valid = in_valid;
        meta1_next.dval  = in_depth_valid;
        meta1_next.zpos  = pos[2] > 32'sd0;
        meta1_next.pos_x = pos[0];
        meta1_next.pos_y = pos[1];
        meta1_next.pos_z = pos[2];
        for (int k = 0; k < 2; k++) begin
            prod_next[k] = focal[k] * pos[k];
        end
        // sign of f * p travels with the magnitude
        meta2_next     = meta1_reg;
        meta2_next.neg = {prod_reg[1][63], prod_reg[0][63]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            for (int j = 0; j < QBITS; j++) begin
                side_reg[j] <= '0;
            end
        end else if (en) begin
            meta1_reg <= meta1_next;
            meta2_reg <= meta2_next;
            side_reg[0] <= meta2_reg;
            for (int j = 1; j < QBITS; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // magnitude of f * p, sign carried alongside
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                prod_reg[k] <= prod_next[k];
                mag_reg[k]  <= prod_reg[k][63] ? 64'(-prod_reg[k]) : 64'(prod_reg[k]);
            end
        end
    end

    dcr_divider u_div_col (
        .aclk     (aclk),
        .en       (en),
        .dividend (mag_reg[0]),
        .divisor  (meta2_reg.pos_z),
        .quotient (quo[0])
    );

    dcr_divider u_div_row (
        .aclk     (aclk),
        .en       (en),
        .dividend (mag_reg[1]),
        .divisor  (meta2_reg.pos_z),
        .quotient (quo[1])
    );

    // rounding to a pixel with truncation toward zero, then bounds
    always_comb begin
        lim[0] = 26'(COLOR_WIDTH);
        lim[1] = 26'(COLOR_HEIGHT);
        for (int k = 0; k < 2; k++) begin
            q[k] = side_reg[QBITS-1].neg[k] ? -$signed({1'b0, quo[k]})
                                             : $signed({1'b0, quo[k]});
            u[k] = U_W'(q[k]) + U_W'(center[k]) + PIX_HALF;
            ok[k] = (u[k] > PIX_NEG_BOUND) && (u[k][U_W-1] || (u[k][U_W-1:12] < lim[k]));
            idx[k] = u[k][U_W-1] ? 11'd0 : u[k][22:12];
        end
        inb = side_reg[QBITS-1].dval && side_reg[QBITS-1].zpos && ok[0] && ok[1];
        res_next.valid       = side_reg[QBITS-1].valid;
        res_next.depth_valid = side_reg[QBITS-1].dval;
        res_next.pos_x       = side_reg[QBITS-1].pos_x;
        res_next.pos_y       = side_reg[QBITS-1].pos_y;
        res_next.pos_z       = side_reg[QBITS-1].pos_z;
        res_next.color_col   = inb ? idx[0] : 11'd0;
        res_next.color_row   = inb ? idx[1] : 11'd0;
        res_next.in_bounds   = inb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
